/* rtl/sliding_window_arq_sender_assert.svh */
// Assertion macros used by the checker of the ARQ sender.
`ifndef SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SWAS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swas assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SWAS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swas assertion failed");

`endif

/* rtl/swas_pkg.sv */
// Package of the ARQ sender: field widths, codes, payload and control types.
`default_nettype none
package swas_pkg;

    localparam int MAX_PACKETS = 1024;
    localparam int SEQ_W       = 10;
    localparam int CNT_W       = 11;
    localparam int RETRY_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_LIMIT   = 2047;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 2'd2;

    localparam logic [CNT_W-1:0]   RST_PACKET_COUNT = 11'd1;
    localparam logic [CNT_W-1:0]   RST_WINDOW_SIZE  = 11'd1;
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES  = 8'd10;

    localparam logic OP_START = 1'b0;
    localparam logic OP_SEND  = 1'b1;

    typedef enum logic [1:0] {
        ST_SEND = 2'd0,
        ST_DONE = 2'd1,
        ST_FAIL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_DONE,
        PH_FAIL
    } t_phase;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MISS,
        S_SLIDE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             op;
        logic             ack_valid;
        logic [SEQ_W-1:0] ack_seq;
    } t_req;

    typedef struct packed {
        logic [SEQ_W-1:0] send_seq;
        logic [SEQ_W-1:0] window_base;
        logic [SEQ_W-1:0] window_last;
        t_status          status;
        logic             retransmit;
        logic             bad_ack;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CNT_W-1:0]     value;
    } t_cfg_req;

    typedef struct packed {
        logic [CNT_W-1:0]   pc;
        logic [CNT_W-1:0]   ws;
        logic [RETRY_W-1:0] max_retries;
    } t_cfg;

    function automatic int pc_limit(input int max_packets);
        return (max_packets < CNT_LIMIT) ? max_packets : CNT_LIMIT;
    endfunction

endpackage
`default_nettype wire

/* rtl/swas_chan_if.sv */
// Valid/ready channel interface with a typed payload.
`default_nettype none
interface swas_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/swas_cfg.sv */
// Configuration registers with the effective packet count and window size.
`default_nettype none
module swas_cfg #(
    parameter int MAX_PACKETS = swas_pkg::MAX_PACKETS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    swas_chan_if.sink         i_cfg,
    output swas_pkg::t_cfg    o_cfg
);

    localparam int PC_MAX = swas_pkg::pc_limit(MAX_PACKETS);
    localparam logic [swas_pkg::CNT_W-1:0] PC_TOP = swas_pkg::CNT_W'(PC_MAX);

    logic [swas_pkg::CNT_W-1:0]   r_packet_count;
    logic [swas_pkg::CNT_W-1:0]   r_window_size;
    logic [swas_pkg::RETRY_W-1:0] r_max_retries;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_count <= swas_pkg::RST_PACKET_COUNT;
            r_window_size  <= swas_pkg::RST_WINDOW_SIZE;
            r_max_retries  <= swas_pkg::RST_MAX_RETRIES;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                swas_pkg::CFG_PACKET_COUNT: r_packet_count <= i_cfg.data.value;
                swas_pkg::CFG_WINDOW_SIZE:  r_window_size  <= i_cfg.data.value;
                swas_pkg::CFG_MAX_RETRIES:  r_max_retries  <=
                    i_cfg.data.value[swas_pkg::RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_packet_count == '0) begin
            o_cfg.pc = swas_pkg::CNT_W'(1);
        end else if (r_packet_count > PC_TOP) begin
            o_cfg.pc = PC_TOP;
        end else begin
            o_cfg.pc = r_packet_count;
        end
        o_cfg.ws          = (r_window_size == '0) ? swas_pkg::CNT_W'(1) : r_window_size;
        o_cfg.max_retries = r_max_retries;
    end

endmodule
`default_nettype wire

/* rtl/swas_ackmem.sv */
// Acknowledgement map: one-bit synchronous memory, one write and one read port.
`default_nettype none
module swas_ackmem #(
    parameter int DEPTH = swas_pkg::MAX_PACKETS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic               o_rdata
);

    logic r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/sliding_window_arq_sender.sv */
// Top level of the windowed ARQ sender: window controller and acknowledgement map.
//
//   channel | dir | payload                                   | accepted when
//   i_req   | in  | op, ack_valid, ack_seq                    | valid & ready
//   o_rsp   | out | send_seq, window_base, window_last,       | valid & ready
//           |     | status, retransmit, bad_ack               |
//   i_cfg   | in  | index, value (packet_count, window_size,  | valid & ready
//           |     | max_retries)                              |
//
// A send that does not end a pass is answered without reading the map. Ending a pass reads
// the map one entry per cycle: first the window, up to its first missing entry, then, with
// all W entries of the window acknowledged, the entries from the base on while it slides.
// A start clears all min(MAX_PACKETS, 2047) entries of the map; after reset the same pass
// runs with i_req held off. One finished request waits in the output register while the
// next is taken; a second one holds the block until o_rsp drains.
`default_nettype none
module sliding_window_arq_sender #(
    parameter int MAX_PACKETS = swas_pkg::MAX_PACKETS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swas_chan_if.sink   i_req,
    swas_chan_if.source o_rsp,
    swas_chan_if.sink   i_cfg
);

    localparam int PC_MAX = swas_pkg::pc_limit(MAX_PACKETS);
    localparam int SW     = $clog2(PC_MAX);
    localparam int AW     = swas_pkg::CNT_W + 1;
    localparam logic [SW-1:0] LAST_ADDR = SW'(PC_MAX - 1);

    swas_pkg::t_cfg   cfg;
    swas_pkg::t_state r_state, n_state;
    swas_pkg::t_phase r_phase, n_phase;
    swas_pkg::t_rsp   r_out, n_out, r_pend, n_pend, res;

    logic [SW-1:0]    r_base, n_base, r_last, n_last, r_cur, n_cur;
    logic [SW-1:0]    r_chk_seq, n_chk_seq, r_clr, n_clr;
    logic [swas_pkg::RETRY_W-1:0] r_retry, n_retry;
    logic [AW-1:0]    r_scan, n_scan;
    logic             r_chk_v, n_chk_v, r_start, n_start, r_bad, n_bad;
    logic             r_out_valid, n_out_valid;
    logic             res_v, out_free, req_fire, bad, issue, rd_data;
    logic             mem_we, mem_wd;
    logic [SW-1:0]    mem_wa, open_b;
    logic [AW-1:0]    base_w, last_w, pc_w, pc_m1, open_w, win_sum, win_end;
    logic [SW-1:0]    win_last;
    swas_pkg::t_status idle_status;

    swas_cfg #(.MAX_PACKETS(MAX_PACKETS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    swas_ackmem #(.DEPTH(PC_MAX), .AW(SW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (r_scan[SW-1:0]),
        .o_rdata (rd_data)
    );

    assign i_req.ready = (r_state == swas_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign base_w  = AW'(r_base);
    assign last_w  = AW'(r_last);
    assign pc_w    = AW'(cfg.pc);
    assign pc_m1   = pc_w - AW'(1);
    assign open_b  = (r_state == swas_pkg::S_CLEAR) ? '0 : r_chk_seq;
    assign open_w  = AW'(open_b);
    assign win_sum = open_w + AW'(cfg.ws);
    assign win_end = (win_sum > pc_w) ? pc_m1 : win_sum - AW'(1);
    assign win_last = win_end[SW-1:0];
    assign bad     = i_req.data.ack_valid && ({1'b0, i_req.data.ack_seq} >= cfg.pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swas_pkg::S_CLEAR;
            r_phase     <= swas_pkg::PH_IDLE;
            r_base      <= '0;
            r_last      <= '0;
            r_cur       <= '0;
            r_retry     <= '0;
            r_clr       <= '0;
            r_start     <= 1'b0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_last      <= n_last;
            r_cur       <= n_cur;
            r_retry     <= n_retry;
            r_clr       <= n_clr;
            r_start     <= n_start;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
        r_scan    <= n_scan;
        r_chk_seq <= n_chk_seq;
        r_bad     <= n_bad;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_comb begin
        case (r_phase)
            swas_pkg::PH_DONE: idle_status = swas_pkg::ST_DONE;
            swas_pkg::PH_FAIL: idle_status = swas_pkg::ST_FAIL;
            default:           idle_status = swas_pkg::ST_SEND;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_base      = r_base;
        n_last      = r_last;
        n_cur       = r_cur;
        n_retry     = r_retry;
        n_clr       = r_clr;
        n_start     = r_start;
        n_chk_v     = r_chk_v;
        n_chk_seq   = r_chk_seq;
        n_scan      = r_scan;
        n_bad       = r_bad;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        mem_we      = 1'b0;
        mem_wa      = r_clr;
        mem_wd      = 1'b0;
        issue       = 1'b0;
        res_v       = 1'b0;
        res         = r_pend;

        unique case (r_state)
            swas_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + SW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_clr   = '0;
                    n_start = 1'b0;
                    n_state = swas_pkg::S_IDLE;
                    if (r_start) begin
                        n_base  = '0;
                        n_last  = win_last;
                        n_cur   = '0;
                        n_retry = '0;
                        n_phase = swas_pkg::PH_SEND;
                        res_v   = 1'b1;
                        res     = '{send_seq: '0, window_base: '0,
                                    window_last: swas_pkg::SEQ_W'(win_last),
                                    status: swas_pkg::ST_SEND,
                                    retransmit: 1'b0, bad_ack: 1'b0};
                    end
                end
            end
            swas_pkg::S_IDLE: begin
                if (req_fire) begin
                    if (i_req.data.op == swas_pkg::OP_START) begin
                        n_start = 1'b1;
                        n_state = swas_pkg::S_CLEAR;
                    end else if (r_phase != swas_pkg::PH_SEND) begin
                        res_v = 1'b1;
                        res   = '{send_seq: swas_pkg::SEQ_W'(
                                      (r_phase == swas_pkg::PH_DONE) ? r_base : r_cur),
                                  window_base: swas_pkg::SEQ_W'(r_base),
                                  window_last: swas_pkg::SEQ_W'(r_last),
                                  status: idle_status,
                                  retransmit: 1'b0, bad_ack: 1'b0};
                    end else begin
                        n_bad  = bad;
                        mem_we = i_req.data.ack_valid && !bad;
                        mem_wa = SW'(i_req.data.ack_seq);
                        mem_wd = 1'b1;
                        if (r_cur < r_last) begin
                            n_cur = r_cur + SW'(1);
                            res_v = 1'b1;
                            res   = '{send_seq: swas_pkg::SEQ_W'(r_cur + SW'(1)),
                                      window_base: swas_pkg::SEQ_W'(r_base),
                                      window_last: swas_pkg::SEQ_W'(r_last),
                                      status: swas_pkg::ST_SEND,
                                      retransmit: 1'b0, bad_ack: bad};
                        end else begin
                            n_scan  = base_w;
                            n_chk_v = 1'b0;
                            n_state = swas_pkg::S_MISS;
                        end
                    end
                end
            end
            swas_pkg::S_MISS: begin
                issue     = (r_scan <= last_w);
                n_scan    = r_scan + AW'(issue);
                n_chk_v   = issue;
                n_chk_seq = r_scan[SW-1:0];
                if (r_chk_v && !rd_data) begin
                    n_chk_v = 1'b0;
                    n_state = swas_pkg::S_IDLE;
                    res_v   = 1'b1;
                    if (r_retry >= cfg.max_retries) begin
                        n_phase = swas_pkg::PH_FAIL;
                        res     = '{send_seq: swas_pkg::SEQ_W'(r_cur),
                                    window_base: swas_pkg::SEQ_W'(r_base),
                                    window_last: swas_pkg::SEQ_W'(r_last),
                                    status: swas_pkg::ST_FAIL,
                                    retransmit: 1'b0, bad_ack: r_bad};
                    end else begin
                        n_retry = r_retry + swas_pkg::RETRY_W'(1);
                        n_cur   = r_base;
                        res     = '{send_seq: swas_pkg::SEQ_W'(r_base),
                                    window_base: swas_pkg::SEQ_W'(r_base),
                                    window_last: swas_pkg::SEQ_W'(r_last),
                                    status: swas_pkg::ST_SEND,
                                    retransmit: 1'b1, bad_ack: r_bad};
                    end
                end else if (!issue) begin
                    n_scan  = base_w;
                    n_chk_v = 1'b0;
                    n_state = swas_pkg::S_SLIDE;
                end
            end
            swas_pkg::S_SLIDE: begin
                issue     = (r_scan < pc_w);
                n_scan    = r_scan + AW'(issue);
                n_chk_v   = issue;
                n_chk_seq = r_scan[SW-1:0];
                if (r_chk_v && !rd_data) begin
                    n_chk_v = 1'b0;
                    n_base  = r_chk_seq;
                    n_last  = win_last;
                    n_cur   = r_chk_seq;
                    n_retry = '0;
                    n_state = swas_pkg::S_IDLE;
                    res_v   = 1'b1;
                    res     = '{send_seq: swas_pkg::SEQ_W'(r_chk_seq),
                                window_base: swas_pkg::SEQ_W'(r_chk_seq),
                                window_last: swas_pkg::SEQ_W'(win_last),
                                status: swas_pkg::ST_SEND,
                                retransmit: 1'b0, bad_ack: r_bad};
                end else if (r_chk_v && (AW'(r_chk_seq) >= pc_m1)) begin
                    n_chk_v = 1'b0;
                    n_base  = r_chk_seq;
                    n_phase = swas_pkg::PH_DONE;
                    n_state = swas_pkg::S_IDLE;
                    res_v   = 1'b1;
                    res     = '{send_seq: swas_pkg::SEQ_W'(r_chk_seq),
                                window_base: swas_pkg::SEQ_W'(r_chk_seq),
                                window_last: swas_pkg::SEQ_W'(r_last),
                                status: swas_pkg::ST_DONE,
                                retransmit: 1'b0, bad_ack: r_bad};
                end else if (!r_chk_v && !issue) begin
                    n_phase = swas_pkg::PH_DONE;
                    n_state = swas_pkg::S_IDLE;
                    res_v   = 1'b1;
                    res     = '{send_seq: swas_pkg::SEQ_W'(r_base),
                                window_base: swas_pkg::SEQ_W'(r_base),
                                window_last: swas_pkg::SEQ_W'(r_last),
                                status: swas_pkg::ST_DONE,
                                retransmit: 1'b0, bad_ack: r_bad};
                end
            end
            swas_pkg::S_EMIT: begin
                res_v = 1'b1;
                res   = r_pend;
            end
            default: begin
                n_state = swas_pkg::S_IDLE;
            end
        endcase

        if (res_v) begin
            if (out_free) begin
                n_out       = res;
                n_out_valid = 1'b1;
                if (r_state == swas_pkg::S_EMIT) begin
                    n_state = swas_pkg::S_IDLE;
                end
            end else begin
                n_pend  = res;
                n_state = swas_pkg::S_EMIT;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/swas_checker.sv */
// Port-level checker of the ARQ sender and its bind to the top level.
`default_nettype none
`include "sliding_window_arq_sender_assert.svh"
module swas_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire swas_pkg::t_rsp i_rsp_data
);

    logic rsp_at_base;
    logic rsp_send;
    logic rsp_done;
    logic rsp_code_ok;

    assign rsp_at_base = (i_rsp_data.send_seq == i_rsp_data.window_base);
    assign rsp_send    = (i_rsp_data.status == swas_pkg::ST_SEND);
    assign rsp_done    = (i_rsp_data.status == swas_pkg::ST_DONE);
    assign rsp_code_ok = rsp_send || rsp_done || (i_rsp_data.status == swas_pkg::ST_FAIL);

    `SWAS_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `SWAS_ASSERT_IMP(a_status_code, i_rsp_valid, rsp_code_ok)
    `SWAS_ASSERT_IMP(a_retx_at_base, i_rsp_valid && i_rsp_data.retransmit, rsp_at_base && rsp_send)
    `SWAS_ASSERT_IMP(a_done_at_base, i_rsp_valid && rsp_done, rsp_at_base && !i_rsp_data.retransmit)

endmodule

bind sliding_window_arq_sender swas_checker u_swas_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
`default_nettype wire
